@@ src/mh_pkg.sv @@
`default_nettype none
package mh_pkg;

  // Number of rotation steps and fraction bits of the angle accumulator.
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;

  // atan(2^-i) table: degrees with TABLE_FRAC fraction bits.
  localparam int TABLE_LEN  = 24;
  localparam int TABLE_FRAC = 24;
  localparam int VEC_SCALE  = 24;

  // Steps beyond the table are not performed.
  localparam int NUM_CELLS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // |X|,|Y| <= 2^15, scaled by 2^24 and grown by the CORDIC gain: below 2^41.
  localparam int VEC_W   = 43;
  // Accumulated angle stays within about +/-100 degrees.
  localparam int ANG_W   = ANGLE_FRAC_BITS + 9;
  localparam int PHI_W   = ANGLE_FRAC_BITS + 7;
  localparam int HEAD_W  = ANGLE_FRAC_BITS + 10;
  localparam int SHIFT_W = 5;
  localparam int DROP    = TABLE_FRAC - ANGLE_FRAC_BITS;

  localparam longint ATAN_TABLE [TABLE_LEN] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  localparam logic [PHI_W-1:0]  PHI_TOP   = PHI_W'(90) << ANGLE_FRAC_BITS;
  localparam logic [HEAD_W-1:0] HALF_TURN = HEAD_W'(180) << ANGLE_FRAC_BITS;
  localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(360) << ANGLE_FRAC_BITS;

  // Table entry i rounded half up to the accumulator's fraction bits.
  function automatic logic signed [ANG_W-1:0] step_angle(input int i);
    longint half;
    longint a;
    half = (longint'(1) << DROP) >>> 1;
    a    = (ATAN_TABLE[i] + half) >>> DROP;
    return ANG_W'(a);
  endfunction

  // One pipeline slot: the sample, its state of rotation and its valid bit.
  typedef struct packed {
    logic                    valid;
    logic                    ok;
    logic signed [15:0]      xv;
    logic signed [15:0]      yv;
    logic signed [15:0]      zv;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [ANG_W-1:0] ang;
  } mh_slot_t;

endpackage
`default_nettype wire

@@ src/mh_cell.sv @@
`default_nettype none
module mh_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [mh_pkg::SHIFT_W-1:0]    shift,
  input  wire logic signed [mh_pkg::ANG_W-1:0] angle,
  input  wire mh_pkg::mh_slot_t              slot_in,
  output mh_pkg::mh_slot_t                   slot_out
);
  import mh_pkg::*;

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  mh_slot_t                slot_next;

  // One vectoring step: rotate toward the X axis, track the angle.
  always_comb begin
    xs        = slot_in.vx >>> shift;
    ys        = slot_in.vy >>> shift;
    slot_next = slot_in;
    if (slot_in.vy >= 0) begin
      slot_next.vx  = slot_in.vx + ys;
      slot_next.vy  = slot_in.vy - xs;
      slot_next.ang = slot_in.ang + angle;
    end else begin
      slot_next.vx  = slot_in.vx - ys;
      slot_next.vy  = slot_in.vy + xs;
      slot_next.ang = slot_in.ang - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else if (en) begin
      slot_out <= slot_next;
    end
  end

endmodule
`default_nettype wire

@@ src/magnetometer_heading.sv @@
`default_nettype none
// Magnetometer heading. Each transfer carries one raw readout (X, Z, Y bytes,
// high byte first) plus a read-ok flag, and produces one result: the signed
// X, Y and Z values and the heading, minus atan2(Y,X) in whole degrees
// 0..359, truncated toward zero. A failed read gives all zeros with
// read_failed set. The angle comes from a row of CORDIC cells, one rotation
// step per cell and a register in each, followed by an output register that
// places the angle in its quadrant. A readout is taken every cycle unless
// in_stall is set; each result passes through the cell registers and then
// the output register. The whole pipeline holds while a finished result
// waits on out_stall, so in_stall follows out_valid && out_stall.
module magnetometer_heading (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        x_high,
  input  wire logic [7:0]        x_low,
  input  wire logic [7:0]        z_high,
  input  wire logic [7:0]        z_low,
  input  wire logic [7:0]        y_high,
  input  wire logic [7:0]        y_low,
  input  wire logic              read_ok,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [15:0]     x_value,
  output logic signed [15:0]     y_value,
  output logic signed [15:0]     z_value,
  output logic [8:0]             heading_deg,
  output logic                   read_failed
);
  import mh_pkg::*;

  logic              en;
  logic signed [16:0] xe;
  logic signed [16:0] ye;
  logic [16:0]        ax;
  logic [16:0]        ay;
  mh_slot_t           slots [NUM_CELLS+1];

  // Advance everything unless a finished result is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Assemble the axes and load magnitudes, scaled up, into the first cell.
  always_comb begin
    xe = 17'(signed'({x_high, x_low}));
    ye = 17'(signed'({y_high, y_low}));
    ax = (xe < 0) ? 17'(-xe) : 17'(xe);
    ay = (ye < 0) ? 17'(-ye) : 17'(ye);
    slots[0].valid = in_valid;
    slots[0].ok    = read_ok;
    slots[0].xv    = signed'({x_high, x_low});
    slots[0].yv    = signed'({y_high, y_low});
    slots[0].zv    = signed'({z_high, z_low});
    slots[0].vx    = signed'({{(VEC_W-17){1'b0}}, ax} << VEC_SCALE);
    slots[0].vy    = signed'({{(VEC_W-17){1'b0}}, ay} << VEC_SCALE);
    slots[0].ang   = '0;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mh_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .shift    (SHIFT_W'(i)),
      .angle    (step_angle(i)),
      .slot_in  (slots[i]),
      .slot_out (slots[i+1])
    );
  end

  mh_slot_t            last;
  logic [PHI_W-1:0]    phi;
  logic [HEAD_W-1:0]   head;
  logic [9:0]          deg;
  logic [8:0]          heading_next;

  // Saturate the angle, place it in its quadrant, drop the fraction.
  always_comb begin
    last = slots[NUM_CELLS];
    if (last.ang < 0) begin
      phi = '0;
    end else if (last.ang > signed'({{(ANG_W-PHI_W){1'b0}}, PHI_TOP})) begin
      phi = PHI_TOP;
    end else begin
      phi = last.ang[PHI_W-1:0];
    end
    if (last.xv > 0) begin
      head = (last.yv > 0) ? FULL_TURN - HEAD_W'(phi) : HEAD_W'(phi);
    end else begin
      head = (last.yv < 0) ? HALF_TURN - HEAD_W'(phi) : HALF_TURN + HEAD_W'(phi);
    end
    deg = head[HEAD_W-1:ANGLE_FRAC_BITS];
    if (deg >= 10'd360) begin
      deg = deg - 10'd360;
    end
    if (last.yv == 0) begin
      heading_next = (last.xv < 0) ? 9'd180 : 9'd0;
    end else if (last.xv == 0) begin
      heading_next = (last.yv < 0) ? 9'd90 : 9'd270;
    end else begin
      heading_next = deg[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  // Zero every value on a failed read.
  always_ff @(posedge clk) begin
    if (en) begin
      x_value     <= last.ok ? last.xv : 16'sd0;
      y_value     <= last.ok ? last.yv : 16'sd0;
      z_value     <= last.ok ? last.zv : 16'sd0;
      heading_deg <= last.ok ? heading_next : 9'd0;
      read_failed <= !last.ok;
    end
  end

endmodule
`default_nettype wire
